// ===== sv/ivs_pkg.sv =====
package ivs_pkg;

  localparam int unsigned MaxLanes          = 8;
  localparam int unsigned DefaultLanes      = 8;
  localparam int unsigned DefaultQueueDepth = 2;
  localparam int unsigned ElemW             = 8;
  localparam int unsigned WordW             = 64;
  localparam int unsigned CountW            = 4;
  localparam int unsigned AccW              = 32;
  // one lane term: 9-bit signed operands
  localparam int unsigned OpW               = ElemW + 1;
  localparam int unsigned TermW             = 2 * OpW;

  localparam logic ModeDot  = 1'b0;
  localparam logic ModeDist = 1'b1;

  typedef struct packed {
    logic [MaxLanes-1:0] mask;
    logic                mode;
    logic                last;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } entry_t;

endpackage

// ===== sv/ivs_front.sv =====
module ivs_front #(
  parameter int unsigned LANES = ivs_pkg::DefaultLanes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ivs_pkg::WordW-1:0]     a_bytes_i,
  input  logic [ivs_pkg::WordW-1:0]     b_bytes_i,
  input  logic [ivs_pkg::CountW-1:0]    lane_count_i,
  input  logic                          last_chunk_i,
  output logic                          q_push_o,
  output ivs_pkg::entry_t               q_entry_o,
  input  logic                          q_full_i
);

  logic mode_q, mode_d;
  logic [ivs_pkg::MaxLanes-1:0] mask;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ivs_pkg::ModeDot;
    end else begin
      mode_q <= mode_d;
    end
  end

  // lane i is live when i < min(lane_count, LANES)
  always_comb begin
    for (int i = 0; i < ivs_pkg::MaxLanes; i++) begin
      mask[i] = (i < LANES) && (lane_count_i > ivs_pkg::CountW'(i));
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o          = '0;
    q_entry_o.ctl.mask = mask;
    q_entry_o.ctl.mode = mode_q;
    q_entry_o.ctl.last = last_chunk_i;
    q_entry_o.a        = a_bytes_i;
    q_entry_o.b        = b_bytes_i;
  end

endmodule

// ===== sv/ivs_queue.sv =====
module ivs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ===== sv/ivs_back.sv =====
module ivs_back #(
  parameter int unsigned LANES = ivs_pkg::DefaultLanes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  ivs_pkg::entry_t                   q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ivs_pkg::AccW-1:0]   sum_result_o
);

  localparam int unsigned TermW = ivs_pkg::TermW;
  localparam int unsigned SumW  = TermW + $clog2(LANES);
  localparam int unsigned AccW  = ivs_pkg::AccW;
  localparam int unsigned OpW   = ivs_pkg::OpW;
  localparam int unsigned ElemW = ivs_pkg::ElemW;

  // stage 1: lane terms
  logic                    s1_valid_q;
  logic                    s1_last_q;
  logic signed [TermW-1:0] s1_term_q [LANES];
  logic signed [TermW-1:0] s1_term_d [LANES];
  logic                    s1_ready;

  // stage 2: chunk sum
  logic                   s2_valid_q;
  logic                   s2_last_q;
  logic signed [SumW-1:0] s2_sum_q, s2_sum_d;
  logic                   s2_ready, s2_fire;

  // accumulate and output
  logic [AccW-1:0] acc_q, acc_d, acc_next;
  logic            out_valid_q, out_valid_d;
  logic [AccW-1:0] out_sum_q;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s2_fire  = s2_valid_q && (!s2_last_q || out_free);
  assign s2_ready = !s2_valid_q || s2_fire;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign q_pop_o  = q_valid_i && s1_ready;

  always_comb begin
    logic signed [ElemW-1:0] ea, eb;
    logic signed [OpW-1:0]   x, y;
    for (int i = 0; i < LANES; i++) begin
      ea = $signed(q_entry_i.a[ElemW*i +: ElemW]);
      eb = $signed(q_entry_i.b[ElemW*i +: ElemW]);
      if (q_entry_i.ctl.mode == ivs_pkg::ModeDist) begin
        x = OpW'(ea) - OpW'(eb);
        y = x;
      end else begin
        x = OpW'(ea);
        y = OpW'(eb);
      end
      s1_term_d[i] = q_entry_i.ctl.mask[i] ? TermW'(x * y) : '0;
    end
  end

  always_comb begin
    s2_sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      s2_sum_d = s2_sum_d + SumW'(s1_term_q[i]);
    end
  end

  assign acc_next = acc_q + {{(AccW - SumW){s2_sum_q[SumW-1]}}, s2_sum_q};

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s2_fire) begin
      if (s2_last_q) begin
        acc_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_last_q <= q_entry_i.ctl.last;
      s1_term_q <= s1_term_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_last_q <= s1_last_q;
      s2_sum_q  <= s2_sum_d;
    end
    if (s2_fire && s2_last_q) begin
      out_sum_q <= acc_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sum_result_o = $signed(out_sum_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_last_q) |=> (acc_q == '0 && out_valid_q))
    else $error("last chunk did not flush accumulator");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_last_q)))
    else $error("stage 1 lost a held chunk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_last_q && !out_free) |=> (s2_valid_q && $stable(acc_q)))
    else $error("accumulator moved while result blocked");

endmodule

// ===== sv/int8_vector_similarity.sv =====
// channel   dir  handshake                  payload
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i (mode: 0 dot, 1 distance)
// in        in   in_valid_i / in_stall_o    a_bytes_i, b_bytes_i, lane_count_i, last_chunk_i
// out       out  out_valid_o / out_stall_i  sum_result_o
//
// One chunk per cycle sustained unless out_stall_i holds a finished result;
// lane multipliers, the lane adder tree and the single accumulator add each
// take one pipeline stage, after the request has been stored in a queue entry.
// Reset clears mode, accumulator, queue and all valid flags; no clearing pass.
// in_stall_o rises only when the request queue is full; out_stall_i holds
// a finished result while non-last chunks keep accumulating behind it.
module int8_vector_similarity #(
  parameter int unsigned LANES       = ivs_pkg::DefaultLanes,
  parameter int unsigned QUEUE_DEPTH = ivs_pkg::DefaultQueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ivs_pkg::WordW-1:0]       a_bytes_i,
  input  logic [ivs_pkg::WordW-1:0]       b_bytes_i,
  input  logic [ivs_pkg::CountW-1:0]      lane_count_i,
  input  logic                            last_chunk_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ivs_pkg::AccW-1:0] sum_result_o
);

  localparam int unsigned EntryW = $bits(ivs_pkg::entry_t);

  logic            q_push, q_full, q_pop, q_valid;
  ivs_pkg::entry_t q_wr_entry, q_rd_entry;

  ivs_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .a_bytes_i    (a_bytes_i),
    .b_bytes_i    (b_bytes_i),
    .lane_count_i (lane_count_i),
    .last_chunk_i (last_chunk_i),
    .q_push_o     (q_push),
    .q_entry_o    (q_wr_entry),
    .q_full_i     (q_full)
  );

  ivs_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wr_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rd_entry)
  );

  ivs_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum_result_o (sum_result_o)
  );

endmodule
